@@ hdl/hpev_pkg.sv @@
// Shared types and constants of the host:port endpoint validator.
`default_nettype none
package hpev_pkg;

    // Character class codes produced by the front end.
    localparam logic [2:0] CLS_DIGIT  = 3'd0;
    localparam logic [2:0] CLS_LETTER = 3'd1;
    localparam logic [2:0] CLS_HYPHEN = 3'd2;
    localparam logic [2:0] CLS_DOT    = 3'd3;
    localparam logic [2:0] CLS_COLON  = 3'd4;
    localparam logic [2:0] CLS_BAD    = 3'd5;

    localparam logic [5:0]  LABEL_MAX   = 6'd63;
    localparam logic [7:0]  OCTET_MAX   = 8'd255;
    localparam logic [2:0]  OCTET_COUNT = 3'd4;
    localparam logic [2:0]  GROUP_SAT   = 3'd7;
    localparam logic [2:0]  PORT_DIGITS = 3'd5;
    localparam logic [16:0] PORT_MAX    = 17'd65535;

    // One classified character as it travels from front to back.
    typedef struct packed {
        logic [2:0] cls;
        logic [3:0] digit;
        logic       last;
    } hpev_item_t;

endpackage
`default_nettype wire

@@ hdl/hpev_front.sv @@
// Front end: accepts characters and classifies them into a registered item.
`default_nettype none
module hpev_front
    import hpev_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] character
    input  wire logic       s_tlast,
    output logic            item_valid,
    output hpev_item_t      item,
    input  wire logic       item_ready
);

    logic       valid_reg;
    logic       valid_next;
    hpev_item_t item_reg;
    hpev_item_t item_next;
    logic       take;

    assign s_tready   = !valid_reg || item_ready;
    assign take       = s_tvalid && s_tready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next      = valid_reg;
        item_next       = item_reg;
        if (valid_reg && item_ready) begin
            valid_next = 1'b0;
        end
        if (take) begin
            valid_next      = 1'b1;
            item_next.last  = s_tlast;
            item_next.digit = s_tdata[3:0];
            if (s_tdata inside {[8'h30:8'h39]}) begin
                item_next.cls = CLS_DIGIT;
            end else if (s_tdata inside {[8'h41:8'h5A], [8'h61:8'h7A]}) begin
                item_next.cls = CLS_LETTER;
            end else if (s_tdata == 8'h2D) begin
                item_next.cls = CLS_HYPHEN;
            end else if (s_tdata == 8'h2E) begin
                item_next.cls = CLS_DOT;
            end else if (s_tdata == 8'h3A) begin
                item_next.cls = CLS_COLON;
            end else begin
                item_next.cls = CLS_BAD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

endmodule
`default_nettype wire

@@ hdl/hpev_queue.sv @@
// Two-entry queue of classified characters between front and back.
`default_nettype none
module hpev_queue
    import hpev_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push_valid,
    output logic            push_ready,
    input  wire hpev_item_t push_item,
    output logic            pop_valid,
    input  wire logic       pop_ready,
    output hpev_item_t      pop_item
);

    hpev_item_t slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

@@ hdl/hpev_back.sv @@
// Back end: per-string syntax state and the registered result.
`default_nettype none
module hpev_back
    import hpev_pkg::*;
#(
    parameter int MAX_LENGTH = 256
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       item_valid,
    output logic            item_ready,
    input  wire hpev_item_t item,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // [0] valid_res, [7:1] zero
);

    localparam int LEN_W = $clog2(MAX_LENGTH + 1);
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_LENGTH);

    logic             in_port_reg,   in_port_next;
    logic [5:0]       label_len_reg, label_len_next;
    logic             prev_hyph_reg, prev_hyph_next;
    logic             all_dig_reg,   all_dig_next;
    logic [7:0]       octet_reg,     octet_next;
    logic             oct_ovf_reg,   oct_ovf_next;
    logic [2:0]       groups_reg,    groups_next;
    logic [16:0]      port_val_reg,  port_val_next;
    logic [2:0]       port_dig_reg,  port_dig_next;
    logic [LEN_W-1:0] total_reg,     total_next;
    logic             failed_reg,    failed_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_bit_reg,   out_bit_next;

    logic        fire;
    logic        ok;
    logic [11:0] octet_prod;
    logic [16:0] port_prod;

    assign item_ready = !item.last || !out_valid_reg || m_tready;
    assign fire       = item_valid && item_ready;
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {7'd0, out_bit_reg};

    assign octet_prod = ({4'd0, octet_reg} << 3) + ({4'd0, octet_reg} << 1)
                        + {8'd0, item.digit};
    assign port_prod  = (port_val_reg << 3) + (port_val_reg << 1) + {13'd0, item.digit};

    always_comb begin
        in_port_next   = in_port_reg;
        label_len_next = label_len_reg;
        prev_hyph_next = prev_hyph_reg;
        all_dig_next   = all_dig_reg;
        octet_next     = octet_reg;
        oct_ovf_next   = oct_ovf_reg;
        groups_next    = groups_reg;
        port_val_next  = port_val_reg;
        port_dig_next  = port_dig_reg;
        total_next     = (total_reg < LEN_LIMIT) ? total_reg + 1'b1 : total_reg;
        failed_next    = failed_reg || (total_next >= LEN_LIMIT);

        if (in_port_reg) begin
            if (item.cls != CLS_DIGIT || port_dig_reg >= PORT_DIGITS) begin
                failed_next = 1'b1;
            end else begin
                port_dig_next = port_dig_reg + 3'd1;
                port_val_next = port_prod;
            end
        end else begin
            case (item.cls)
                CLS_COLON: begin
                    if (label_len_reg == 6'd0 || prev_hyph_reg) begin
                        failed_next = 1'b1;
                    end
                    if (all_dig_reg && (oct_ovf_reg || groups_reg != OCTET_COUNT)) begin
                        failed_next = 1'b1;
                    end
                    in_port_next = 1'b1;
                end
                CLS_DOT: begin
                    if (label_len_reg == 6'd0 || prev_hyph_reg) begin
                        failed_next = 1'b1;
                    end
                    label_len_next = 6'd0;
                    octet_next     = 8'd0;
                    if (groups_reg < GROUP_SAT) begin
                        groups_next = groups_reg + 3'd1;
                    end
                    prev_hyph_next = 1'b0;
                end
                CLS_DIGIT, CLS_LETTER, CLS_HYPHEN: begin
                    if (label_len_reg == 6'd0 && item.cls == CLS_HYPHEN) begin
                        failed_next = 1'b1;
                    end
                    if (label_len_reg >= LABEL_MAX) begin
                        failed_next = 1'b1;
                    end else begin
                        label_len_next = label_len_reg + 6'd1;
                    end
                    if (item.cls != CLS_DIGIT) begin
                        all_dig_next = 1'b0;
                    end else if (all_dig_reg) begin
                        // A dotted-quad octet clamps at its ceiling once it overflows.
                        if (octet_prod > {4'd0, OCTET_MAX}) begin
                            oct_ovf_next = 1'b1;
                            octet_next   = OCTET_MAX;
                        end else begin
                            octet_next = octet_prod[7:0];
                        end
                    end
                    prev_hyph_next = (item.cls == CLS_HYPHEN);
                end
                default: begin
                    failed_next = 1'b1;
                end
            endcase
        end

        ok = !failed_next && in_port_next && (port_dig_next != 3'd0)
             && (port_val_next != 17'd0) && (port_val_next <= PORT_MAX);

        out_valid_next = out_valid_reg && !m_tready;
        out_bit_next   = out_bit_reg;
        if (fire && item.last) begin
            out_valid_next = 1'b1;
            out_bit_next   = ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (fire && item.last)) begin
            in_port_reg   <= 1'b0;
            label_len_reg <= 6'd0;
            prev_hyph_reg <= 1'b0;
            all_dig_reg   <= 1'b1;
            octet_reg     <= 8'd0;
            oct_ovf_reg   <= 1'b0;
            groups_reg    <= 3'd1;
            port_val_reg  <= 17'd0;
            port_dig_reg  <= 3'd0;
            total_reg     <= '0;
            failed_reg    <= 1'b0;
        end else if (fire) begin
            in_port_reg   <= in_port_next;
            label_len_reg <= label_len_next;
            prev_hyph_reg <= prev_hyph_next;
            all_dig_reg   <= all_dig_next;
            octet_reg     <= octet_next;
            oct_ovf_reg   <= oct_ovf_next;
            groups_reg    <= groups_next;
            port_val_reg  <= port_val_next;
            port_dig_reg  <= port_dig_next;
            total_reg     <= total_next;
            failed_reg    <= failed_next;
        end
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        out_bit_reg <= out_bit_next;
    end

endmodule
`default_nettype wire

@@ hdl/host_port_endpoint_validator_core.sv @@
// Top level of the host:port endpoint validator.
// The result of a string appears on m_tvalid after its last character has passed
// the front register and the queue and updated the result register. Throughput: one
// character per cycle while no last character waits on a full result register.
// aresetn is synchronous and active low; it empties the front register, the queue and
// the result register, and returns the string state to its start-of-string values.
`default_nettype none
module host_port_endpoint_validator_core
    import hpev_pkg::*;
#(
    parameter int MAX_LENGTH = 256
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] character
    input  wire logic       s_tlast,   // last character of the string
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // [0] valid_res, [7:1] zero
);

    // The front end classifies each character into a digit, letter, hyphen,
    // dot, colon or bad byte and registers it with its digit value and the
    // last flag. The queue lets the front keep taking characters while the
    // back end waits for its result register to drain.
    logic       front_valid;
    logic       front_ready;
    hpev_item_t front_item;
    logic       back_valid;
    logic       back_ready;
    hpev_item_t back_item;

    hpev_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .item_valid (front_valid),
        .item       (front_item),
        .item_ready (front_ready)
    );

    hpev_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_item   (back_item)
    );

    // The back end tracks labels, octets, the port and the overall length.
    // Only a last character needs room in the result register, so ordinary
    // characters keep flowing while a result waits to be taken.
    hpev_back #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (back_valid),
        .item_ready (back_ready),
        .item       (back_item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
`default_nettype wire
